### rtl/assert_macros.svh
// Assertion macros used by the supervisor top level.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define EFFP_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("supervisor invariant violated");

// Check that a consequent holds in the cycle after an antecedent.
`define EFFP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("supervisor sequencing violated");

`endif

### rtl/effp_pkg.sv
// Types, codes and helpers for the eFuse fault-protection supervisor.
// No dependencies; imported by effp_ctrl, the top level and the testbench.
`timescale 1ns / 1ps

package effp_pkg;

	// Operation codes carried on the input tuser
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_ENABLE  = 2'd1;
	localparam logic [1:0] OP_DISABLE = 2'd2;

	// Mode codes reported on the result
	localparam logic [1:0] MODE_OFF     = 2'd0;
	localparam logic [1:0] MODE_STARTUP = 2'd1;
	localparam logic [1:0] MODE_RUN     = 2'd2;
	localparam logic [1:0] MODE_FAULT   = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_DETECT_DELAY    = 2'd0;
	localparam logic [1:0] REG_STARTUP_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_DROP_LIMIT      = 2'd2;

	// Configuration reset values
	localparam logic [15:0] DETECT_DELAY_RST    = 16'd100;
	localparam logic [15:0] STARTUP_TIMEOUT_RST = 16'd500;
	localparam logic [15:0] DROP_LIMIT_RST      = 16'd100;

	typedef enum logic [3:0] {
		ST_OFF     = 4'b0001,
		ST_STARTUP = 4'b0010,
		ST_RUN     = 4'b0100,
		ST_FAULT   = 4'b1000
	} state_t;

	// One input item
	typedef struct packed {
		logic [1:0] operation;
		logic       power_good;
		logic       fault_active;
	} item_t;

	// One result item; mode lands in the lowest bits
	typedef struct packed {
		logic [15:0] fault_total;
		logic        power_ok;
		logic        switch_on;
		logic [1:0]  mode;
	} result_t;

	// Configuration write
	typedef struct packed {
		logic        wr;
		logic [1:0]  index;
		logic [15:0] data;
	} cfg_wr_t;

	function automatic logic [15:0] sat_inc16(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [1:0] mode_code(input state_t s);
		logic [1:0] m;
		unique case (s)
			ST_OFF:     m = MODE_OFF;
			ST_STARTUP: m = MODE_STARTUP;
			ST_RUN:     m = MODE_RUN;
			ST_FAULT:   m = MODE_FAULT;
			default:    m = MODE_OFF;
		endcase
		return m;
	endfunction

endpackage

### rtl/effp_ctrl.sv
// Supervisor state, configuration registers and next-state logic.
// Depends on effp_pkg; the result is the state after the current item.
`timescale 1ns / 1ps

module effp_ctrl
	import effp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_wr_t cfg,
	input  logic    item_fire,
	input  item_t   item,
	output result_t result
);

	state_t      state_q, state_d;
	logic        pending_q, pending_d;
	logic [15:0] startup_ticks_q, startup_ticks_d;
	logic        drop_active_q, drop_active_d;
	logic [15:0] drop_ticks_q, drop_ticks_d;
	logic [15:0] fault_cnt_q, fault_cnt_d;
	logic [15:0] detect_delay_q, startup_timeout_q, drop_limit_q;

	logic        enter;
	state_t      target;
	logic [15:0] elapsed;
	logic [15:0] drop_next;
	logic [15:0] fault_base;

	// Decode the item and work out the state after it
	always_comb begin
		pending_d       = pending_q;
		startup_ticks_d = startup_ticks_q;
		drop_active_d   = drop_active_q;
		drop_ticks_d    = drop_ticks_q;
		fault_base      = fault_cnt_q;
		enter           = 1'b0;
		target          = state_q;
		elapsed         = sat_inc16(startup_ticks_q);
		drop_next       = sat_inc16(drop_ticks_q);

		case (item.operation)
			OP_TICK: begin
				unique case (state_q)
					ST_OFF: begin
						if (pending_q) begin
							pending_d = 1'b0;
							enter     = 1'b1;
							target    = ST_STARTUP;
						end
					end
					ST_STARTUP: begin
						startup_ticks_d = elapsed;
						if (elapsed >= detect_delay_q) begin
							if (item.fault_active) begin
								enter  = 1'b1;
								target = ST_FAULT;
							end else if (item.power_good) begin
								enter  = 1'b1;
								target = ST_RUN;
							end else if (elapsed >= startup_timeout_q) begin
								enter  = 1'b1;
								target = ST_FAULT;
							end
						end
					end
					ST_RUN: begin
						if (item.fault_active) begin
							enter  = 1'b1;
							target = ST_FAULT;
						end else if (item.power_good) begin
							drop_active_d = 1'b0;
							drop_ticks_d  = '0;
						end else if (!drop_active_q) begin
							drop_active_d = 1'b1;
							drop_ticks_d  = '0;
						end else begin
							drop_ticks_d = drop_next;
							if (drop_next >= drop_limit_q) begin
								enter  = 1'b1;
								target = ST_FAULT;
							end
						end
					end
					ST_FAULT: begin
					end
					default: begin
					end
				endcase
			end
			OP_ENABLE: begin
				if (state_q != ST_FAULT) pending_d = 1'b1;
			end
			OP_DISABLE: begin
				pending_d  = 1'b0;
				fault_base = '0;
				enter      = 1'b1;
				target     = ST_OFF;
			end
			default: begin
			end
		endcase

		// Mode entry side effects
		state_d     = target;
		fault_cnt_d = fault_base;
		if (enter) begin
			drop_active_d = 1'b0;
			drop_ticks_d  = '0;
			if (target == ST_STARTUP) startup_ticks_d = '0;
			if (target == ST_FAULT) fault_cnt_d = sat_inc16(fault_base);
		end
	end

	// Advance the supervisor state on each processed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_OFF;
			pending_q       <= 1'b1;
			startup_ticks_q <= '0;
			drop_active_q   <= 1'b0;
			drop_ticks_q    <= '0;
			fault_cnt_q     <= '0;
		end else if (item_fire) begin
			state_q         <= state_d;
			pending_q       <= pending_d;
			startup_ticks_q <= startup_ticks_d;
			drop_active_q   <= drop_active_d;
			drop_ticks_q    <= drop_ticks_d;
			fault_cnt_q     <= fault_cnt_d;
		end
	end

	// Configuration registers; unknown indexes drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detect_delay_q    <= DETECT_DELAY_RST;
			startup_timeout_q <= STARTUP_TIMEOUT_RST;
			drop_limit_q      <= DROP_LIMIT_RST;
		end else if (cfg.wr) begin
			unique case (cfg.index)
				REG_DETECT_DELAY:    detect_delay_q    <= cfg.data;
				REG_STARTUP_TIMEOUT: startup_timeout_q <= cfg.data;
				REG_DROP_LIMIT:      drop_limit_q      <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Result reflects the state after the item
	always_comb begin
		result.mode        = mode_code(state_d);
		result.switch_on   = (state_d == ST_STARTUP) || (state_d == ST_RUN);
		result.power_ok    = (state_d == ST_RUN);
		result.fault_total = fault_cnt_d;
	end

endmodule

### rtl/efuse_fault_protection_fsm.sv
// Path: an input transfer goes into the input register, then its result into the result register on m_axis.
// Throughput: one item per cycle while the result register is not stalled; the supervisor state updates once per item.
// Stalls: the result register holds while m_axis_tready is low; input keeps flowing until full.
// Reset: arst_n clears to OFF with an enable pending, counters zero, registers at defaults.
// Configuration writes are always taken; cfg_ready is tied high.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efuse_fault_protection_fsm
	import effp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] power_good, [1] fault_active, [7:2] zero
	input  logic [1:0]  s_axis_tuser,  // [1:0] operation
	// Result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // [1:0] mode, [2] switch_on, [3] power_ok,
	                                   // [19:4] fault_total, [23:20] zero
);

	logic    valid_s1;
	item_t   item_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t result_d;
	logic    advance;
	logic    fire;
	cfg_wr_t cfg_wr;
	logic    exp_switch_on;
	logic    exp_power_ok;
	logic    disable_fire;
	logic    off_cleared;

	assign advance       = !out_valid_q || m_axis_tready;
	assign fire          = valid_s1 && advance;
	assign s_axis_tready = !valid_s1 || advance;
	assign cfg_ready     = 1'b1;

	assign cfg_wr.wr    = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	// Input register: take a transfer whenever the stage is free or moving
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.operation    <= s_axis_tuser;
			item_s1.power_good   <= s_axis_tdata[0];
			item_s1.fault_active <= s_axis_tdata[1];
		end
	end

	effp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_wr),
		.item_fire (fire),
		.item      (item_s1),
		.result    (result_d)
	);

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) result_q <= result_d;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, result_q};

	// Expected flags for the held result
	assign exp_switch_on = (result_q.mode == MODE_STARTUP) || (result_q.mode == MODE_RUN);
	assign exp_power_ok  = (result_q.mode == MODE_RUN);
	assign disable_fire  = fire && (item_s1.operation == OP_DISABLE);
	assign off_cleared   = (result_q.mode == MODE_OFF) && (result_q.fault_total == 16'd0);

	// A processed item always shows up as a result on the next cycle
	`EFFP_ASSERT_NEXT(a_fire_gives_result, fire, m_axis_tvalid)
	// Switch is on exactly in startup and run
	`EFFP_ASSERT_ALWAYS(a_switch_matches_mode, !out_valid_q || (result_q.switch_on == exp_switch_on))
	// Power-ok only in run
	`EFFP_ASSERT_ALWAYS(a_power_ok_run, !out_valid_q || (result_q.power_ok == exp_power_ok))
	// A disable always reports off with a cleared fault count
	`EFFP_ASSERT_NEXT(a_disable_clears, disable_fire, off_cleared)

endmodule

### tb/testbench.sv
// Self-checking bench for the eFuse supervisor: queued commands go in, status comes back.
// A built-in model of the supervisor predicts each status. Needs effp_pkg and the top level.
`timescale 1ns / 1ps

module testbench
	import effp_pkg::*;
();

	// Codes the package leaves unnamed
	localparam logic [1:0] OP_SPARE   = 2'd3;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // [0] power_good, [1] fault_active, [7:2] zero
	logic [1:0]  s_axis_tuser = '0;   // [1:0] operation
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;        // [1:0] mode, [2] switch_on, [3] power_ok,
	                                  // [19:4] fault_total, [23:20] zero

	efuse_fault_protection_fsm DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	item_t   supervisor_cmds[$];
	result_t status_due[$];
	int      queued_total = 0;
	int      errors = 0;
	int      tx_idle_pct = 20;
	int      rx_idle_pct = 50;
	logic    rx_hold = 1'b0;
	bit      pressure_go = 1'b0;

	// Supervisor model state and its limits
	logic [1:0]  sv_mode = MODE_OFF;
	logic        sv_pending = 1'b1;
	logic [15:0] sv_start_cnt = '0;
	logic        sv_drop_armed = 1'b0;
	logic [15:0] sv_drop_cnt = '0;
	logic [15:0] sv_faults = '0;
	logic [15:0] lim_detect = DETECT_DELAY_RST;
	logic [15:0] lim_timeout = STARTUP_TIMEOUT_RST;
	logic [15:0] lim_drop = DROP_LIMIT_RST;

	// Change mode; every entry disarms the drop timer, FAULT bumps the count
	function automatic void switch_mode(input logic [1:0] m);
		sv_mode = m;
		sv_drop_armed = 1'b0;
		sv_drop_cnt = '0;
		if (m == MODE_STARTUP)
			sv_start_cnt = '0;
		if (m == MODE_FAULT && sv_faults != 16'hFFFF)
			sv_faults = sv_faults + 16'd1;
	endfunction

	// Advance the model by one command and return the status it reports
	function automatic result_t supervise(input logic [1:0] op, input logic pg,
	                                      input logic flt);
		result_t r;
		case (op)
			OP_TICK: begin
				case (sv_mode)
					MODE_OFF: begin
						if (sv_pending) begin
							sv_pending = 1'b0;
							switch_mode(MODE_STARTUP);
						end
					end
					MODE_STARTUP: begin
						if (sv_start_cnt != 16'hFFFF)
							sv_start_cnt = sv_start_cnt + 16'd1;
						if (sv_start_cnt >= lim_detect) begin
							if (flt)
								switch_mode(MODE_FAULT);
							else if (pg)
								switch_mode(MODE_RUN);
							else if (sv_start_cnt >= lim_timeout)
								switch_mode(MODE_FAULT);
						end
					end
					MODE_RUN: begin
						if (flt) begin
							switch_mode(MODE_FAULT);
						end else if (pg) begin
							sv_drop_armed = 1'b0;
							sv_drop_cnt = '0;
						end else if (!sv_drop_armed) begin
							sv_drop_armed = 1'b1;
							sv_drop_cnt = '0;
						end else begin
							if (sv_drop_cnt != 16'hFFFF)
								sv_drop_cnt = sv_drop_cnt + 16'd1;
							if (sv_drop_cnt >= lim_drop)
								switch_mode(MODE_FAULT);
						end
					end
					default: ;
				endcase
			end
			OP_ENABLE: begin
				if (sv_mode != MODE_FAULT)
					sv_pending = 1'b1;
			end
			OP_DISABLE: begin
				sv_pending = 1'b0;
				sv_faults = '0;
				switch_mode(MODE_OFF);
			end
			default: ;
		endcase
		r.mode = sv_mode;
		r.switch_on = (sv_mode == MODE_STARTUP || sv_mode == MODE_RUN);
		r.power_ok = (sv_mode == MODE_RUN);
		r.fault_total = sv_faults;
		return r;
	endfunction

	// Driver: predict each accepted command, then offer the next one or idle
	always @(posedge clk) begin : drive_cmds
		item_t nxt;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				status_due.push_back(supervise(s_axis_tuser, s_axis_tdata[0],
				                               s_axis_tdata[1]));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (supervisor_cmds.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					nxt = supervisor_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= nxt.operation;
					s_axis_tdata <= {6'b0, nxt.fault_active, nxt.power_good};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each status transfer against the oldest prediction
	always @(posedge clk) begin : check_status
		result_t got;
		result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[19:0];
				if (status_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected status, expected none, actual %0d/%0d/%0d/%0d",
						$time, got.mode, got.switch_on, got.power_ok, got.fault_total);
				end else begin
					want = status_due.pop_front();
					if (got.mode !== want.mode || got.switch_on !== want.switch_on ||
					    got.power_ok !== want.power_ok || got.fault_total !== want.fault_total) begin
						errors++;
						$display("%0t: mismatch, expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
							$time, want.mode, want.switch_on, want.power_ok, want.fault_total,
							got.mode, got.switch_on, got.power_ok, got.fault_total);
					end
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Hold off the receiver long enough for the block to back up its input
	initial begin : rx_pressure
		wait (pressure_go);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (200) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin : watchdog
		#2_000_000;
		$display("testbench failed");
		$finish;
	end

	function automatic void push_cmd(input logic [1:0] op, input logic pg, input logic flt);
		item_t it;
		it.operation = op;
		it.power_good = pg;
		it.fault_active = flt;
		supervisor_cmds.push_back(it);
		queued_total++;
	endfunction

	// Queue start-up sessions: an occasional random command, a likely disable and enable, then ticks in power-good bursts
	task automatic queue_sessions(input int n_items, input int burst);
		int         target;
		int         ticks;
		int         len;
		logic       level;
		logic [3:0] raw;
		target = queued_total + n_items;
		while (queued_total < target) begin
			if ($urandom_range(0, 9) == 0) begin
				raw = 4'($urandom_range(0, 15));
				push_cmd(raw[3:2], raw[1], raw[0]);
			end
			if ($urandom_range(0, 3) != 0)
				push_cmd(OP_DISABLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 4) != 0)
				push_cmd(OP_ENABLE, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			ticks = $urandom_range(burst, 6 * burst + 8);
			while (ticks > 0) begin
				level = 1'($urandom_range(0, 1));
				len = $urandom_range(1, burst + 2);
				while (len > 0 && ticks > 0) begin
					if ($urandom_range(0, 29) == 0)
						push_cmd(OP_ENABLE, 1'($urandom_range(0, 1)),
						         1'($urandom_range(0, 1)));
					push_cmd(OP_TICK, level, $urandom_range(0, 8 * burst + 20) == 0);
					len--;
					ticks--;
				end
			end
		end
	endtask

	// Wait until every queued command has produced its status
	task automatic drain;
		while (supervisor_cmds.size() != 0 || s_axis_tvalid || status_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_DETECT_DELAY:    lim_detect = val;
			REG_STARTUP_TIMEOUT: lim_timeout = val;
			REG_DROP_LIMIT:      lim_drop = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(input logic [15:0] dly, input logic [15:0] tmo,
	                          input logic [15:0] drp);
		write_reg(REG_DETECT_DELAY, dly);
		write_reg(REG_STARTUP_TIMEOUT, tmo);
		write_reg(REG_DROP_LIMIT, drp);
	endtask

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset defaults: the pending enable starts up on the first tick
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b1, 1'b0);
		push_cmd(OP_SPARE, 1'b1, 1'b1);
		push_cmd(OP_ENABLE, 1'b0, 1'b0);
		push_cmd(OP_DISABLE, 1'b1, 1'b1);
		push_cmd(OP_TICK, 1'b1, 1'b0);
		drain();

		// Short limits: fault over power-good, enable ignored in fault
		set_limits(16'd1, 16'd3, 16'd2);
		push_cmd(OP_ENABLE, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b1, 1'b1);
		push_cmd(OP_ENABLE, 1'b1, 1'b1);
		push_cmd(OP_TICK, 1'b1, 1'b0);
		push_cmd(OP_DISABLE, 1'b0, 1'b0);
		// Reach run, then debounce a drop, recover, and drop for good
		push_cmd(OP_ENABLE, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b1, 1'b0);
		push_cmd(OP_ENABLE, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b1, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		// Startup timeout without power-good
		push_cmd(OP_DISABLE, 1'b0, 1'b0);
		push_cmd(OP_ENABLE, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		push_cmd(OP_TICK, 1'b0, 1'b0);
		drain();

		// Zero limits, with a long receiver stall early on
		set_limits(16'd0, 16'd0, 16'd0);
		queue_sessions(250, 3);
		pressure_go = 1'b1;
		drain();

		// Timeout below the detect delay
		set_limits(16'd5, 16'd2, 16'd3);
		queue_sessions(300, 6);
		drain();

		tx_idle_pct = 50;
		rx_idle_pct = 20;
		set_limits(16'd2, 16'd12, 16'd6);
		queue_sessions(350, 10);
		drain();

		set_limits(DETECT_DELAY_RST, STARTUP_TIMEOUT_RST, DROP_LIMIT_RST);
		queue_sessions(550, 110);
		drain();

		// Full-scale limits; the spare index must not disturb anything
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_limits(16'd0, 16'hFFFF, 16'hFFFF);
		write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
		queue_sessions(200, 8);
		drain();

		set_limits(16'hFFFF, 16'd1, 16'd1);
		queue_sessions(120, 4);
		drain();

		// Let any stray status show up before the verdict
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
